### hw/rtl/crg_pkg.sv
// crg_pkg: types, register codes and constants for the column range gather unit
// no dependencies; used by column_range_gather_unit
`timescale 1ns / 1ps

package crg_pkg;

	localparam int LINE_BYTES  = 1024;
	localparam int MAX_COLUMNS = 16;
	localparam int ADDR_W      = $clog2(LINE_BYTES);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int COL_W       = 10;
	localparam int CNT_W       = 5;
	localparam int TABLE_REGS  = 4;
	localparam int TABLE_W     = 40;
	localparam int CFG_IDX_W   = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_0      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_1      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_2      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_3      = 3'd4;

	localparam logic       REQ_PUSH   = 1'b0;
	localparam logic       REQ_PULL   = 1'b1;
	localparam logic [7:0] TERMINATOR = 8'd0;

	typedef struct packed {
		logic       req_type;
		logic [7:0] line_byte;
		logic       line_end;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ
	} state_t;

	typedef logic [TABLE_W-1:0] table_t [TABLE_REGS];

	function automatic logic [COL_W-1:0] column_at(input table_t tbl, input logic [3:0] i);
		logic [TABLE_W-1:0] word;
		word = tbl[i[3:2]];
		return word[i[1:0]*COL_W +: COL_W];
	endfunction

endpackage

### hw/rtl/column_range_gather_unit.sv
// column_range_gather_unit: line store and column range gather sequencer
// depends on crg_pkg
`timescale 1ns / 1ps

// Usage
// Items enter on req when start is high and busy is low. A push (req_type 0)
// stores its byte if non-zero and the line is not full, and gives no result. A
// pull (req_type 1) on a complete line returns one rsp, marked by done for
// exactly one cycle; a pull on an incomplete line is dropped with no result.
// The sequencer walks the column table one range per cycle, then reads the
// 1024 x 8 line store through its registered read port; a terminator skips
// the read, and reversed or used-up ranges are stepped over. busy stays high
// until the result is registered, and the next item can enter on the cycle
// in which done is high. Pushes run back to back at one per cycle while no
// pull runs. Configuration is written through wr_en, wr_index and wr_data,
// by the user only while idle; the block does not enforce this. Reset clears
// all line and output progress and the registers; the line store holds no
// reset value and needs no clearing pass, since every read falls below the
// current line length. The receiver has no way to stall: done is a strobe.
module column_range_gather_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  crg_pkg::req_t                 req,
	output logic                          done,
	output crg_pkg::rsp_t                 rsp,
	input  logic                          wr_en,
	input  logic [crg_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [crg_pkg::TABLE_W-1:0]   wr_data
);

	logic [7:0] store_mem [crg_pkg::LINE_BYTES];
	logic [7:0] rd_data_q;

	crg_pkg::state_t             state_q, state_d;
	logic [crg_pkg::LEN_W-1:0]   len_q, len_d;
	logic                        complete_q, complete_d;
	logic [crg_pkg::CNT_W-1:0]   cursor_q, cursor_d;
	logic [crg_pkg::ADDR_W-1:0]  copy_q, copy_d;
	logic [crg_pkg::ADDR_W-1:0]  emitted_q, emitted_d;
	logic                        out_done_q, out_done_d;
	logic                        done_q, done_d;
	crg_pkg::rsp_t               rsp_q, rsp_d;

	logic [crg_pkg::CNT_W-1:0]   count_q;
	crg_pkg::table_t             table_q;

	logic                        accept;
	logic                        wr_store;
	logic [crg_pkg::ADDR_W-1:0]  wr_addr;
	logic                        rd_en;
	logic [crg_pkg::ADDR_W-1:0]  rd_addr;

	logic [crg_pkg::CNT_W-1:0]   n_valid;
	logic [crg_pkg::CNT_W-1:0]   cursor_nx;
	logic [crg_pkg::COL_W-1:0]   col_s, col_e;
	logic                        has_end;
	logic [crg_pkg::LEN_W-1:0]   pos;

	assign accept    = start && !busy;
	assign busy      = (state_q != crg_pkg::ST_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign n_valid   = (count_q > crg_pkg::CNT_W'(crg_pkg::MAX_COLUMNS)) ?
		crg_pkg::CNT_W'(crg_pkg::MAX_COLUMNS) : count_q;
	assign cursor_nx = cursor_q + crg_pkg::CNT_W'(1);
	assign col_s     = crg_pkg::column_at(table_q, cursor_q[3:0]);
	assign col_e     = crg_pkg::column_at(table_q, cursor_nx[3:0]);
	assign has_end   = (cursor_nx < n_valid);
	assign pos       = crg_pkg::LEN_W'(col_s) + crg_pkg::LEN_W'(copy_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < crg_pkg::TABLE_REGS; i++) table_q[i] <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				crg_pkg::CFG_COLUMN_COUNT: count_q    <= wr_data[crg_pkg::CNT_W-1:0];
				crg_pkg::CFG_TABLE_0:      table_q[0] <= wr_data;
				crg_pkg::CFG_TABLE_1:      table_q[1] <= wr_data;
				crg_pkg::CFG_TABLE_2:      table_q[2] <= wr_data;
				crg_pkg::CFG_TABLE_3:      table_q[3] <= wr_data;
				default: ;
			endcase
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (wr_store) store_mem[wr_addr] <= req.line_byte;
		if (rd_en) rd_data_q <= store_mem[rd_addr];
	end

	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		complete_d = complete_q;
		cursor_d   = cursor_q;
		copy_d     = copy_q;
		emitted_d  = emitted_q;
		out_done_d = out_done_q;
		done_d     = 1'b0;
		rsp_d      = rsp_q;
		wr_store   = 1'b0;
		wr_addr    = len_q[crg_pkg::ADDR_W-1:0];
		rd_en      = 1'b0;
		rd_addr    = pos[crg_pkg::ADDR_W-1:0];
		unique case (state_q)
			crg_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.req_type == crg_pkg::REQ_PUSH) begin
						if (complete_q) begin
							len_d      = '0;
							complete_d = 1'b0;
							cursor_d   = '0;
							copy_d     = '0;
							emitted_d  = '0;
							out_done_d = 1'b0;
							wr_addr    = '0;
						end
						if (req.line_byte != crg_pkg::TERMINATOR &&
							(complete_q || !len_q[crg_pkg::ADDR_W])) begin
							wr_store = 1'b1;
							len_d    = (complete_q ? '0 : len_q) + crg_pkg::LEN_W'(1);
						end
						if (req.line_end) complete_d = 1'b1;
					end else if (complete_q) begin
						state_d = crg_pkg::ST_SCAN;
					end
				end
			end
			crg_pkg::ST_SCAN: begin
				if (out_done_q ||
					emitted_q == crg_pkg::ADDR_W'(crg_pkg::LINE_BYTES - 1) ||
					cursor_q >= n_valid ||
					crg_pkg::LEN_W'(col_s) >= len_q) begin
					out_done_d     = 1'b1;
					done_d         = 1'b1;
					rsp_d.out_byte = crg_pkg::TERMINATOR;
					rsp_d.out_last = 1'b1;
					state_d        = crg_pkg::ST_IDLE;
				end else if (has_end && (col_e < col_s || pos > crg_pkg::LEN_W'(col_e))) begin
					cursor_d = cursor_q + crg_pkg::CNT_W'(2);
					copy_d   = '0;
				end else if (pos >= len_q) begin
					out_done_d     = 1'b1;
					done_d         = 1'b1;
					rsp_d.out_byte = crg_pkg::TERMINATOR;
					rsp_d.out_last = 1'b1;
					state_d        = crg_pkg::ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					state_d = crg_pkg::ST_READ;
				end
			end
			crg_pkg::ST_READ: begin
				done_d         = 1'b1;
				rsp_d.out_byte = rd_data_q;
				rsp_d.out_last = 1'b0;
				copy_d         = copy_q + crg_pkg::ADDR_W'(1);
				emitted_d      = emitted_q + crg_pkg::ADDR_W'(1);
				state_d        = crg_pkg::ST_IDLE;
			end
			default: state_d = crg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= crg_pkg::ST_IDLE;
			len_q      <= '0;
			complete_q <= 1'b0;
			cursor_q   <= '0;
			copy_q     <= '0;
			emitted_q  <= '0;
			out_done_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			len_q      <= len_d;
			complete_q <= complete_d;
			cursor_q   <= cursor_d;
			copy_q     <= copy_d;
			emitted_q  <= emitted_d;
			out_done_q <= out_done_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	// checks
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe high on two cycles in a row");

	a_last_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.out_last) |-> (rsp.out_byte == crg_pkg::TERMINATOR))
		else $error("terminator carries a non-zero byte");

	a_scan_needs_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != crg_pkg::ST_IDLE) |-> complete_q)
		else $error("pull in progress on an incomplete line");

	a_read_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (pos < len_q))
		else $error("line store read at or past line length");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) != crg_pkg::ST_IDLE)
		else $error("result without a pull in progress");

endmodule
